// File: hw/rtl/ffba_pkg.sv
// ffba_pkg: sizes, field widths, operation and status codes of the
// first-fit block allocator. No dependencies.
package ffba_pkg;

  localparam int CELLS       = 128;
  localparam int HANDLE_BITS = 15;

  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W  = $clog2(CELLS + 1);

  localparam int FUNC_W   = 2;
  localparam int LEN_W    = 8;
  localparam int EH_W     = 16;
  localparam int STATUS_W = 2;
  localparam int GH_W     = 15;
  localparam int CFG_W    = 8;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  localparam logic [HANDLE_BITS-1:0] HANDLE_MAX = '1;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ERASE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DEFRAG = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ILLEGAL = 2'd2;

  localparam logic [CFG_W-1:0] MEM_SIZE_RST = 8'd128;

endpackage

// File: hw/rtl/first_fit_block_allocator.sv
// first_fit_block_allocator: first-fit cell allocator over a 1r1w cell memory, uses ffba_pkg
// alloc: scan, then fill one cell a cycle, then the result beat; a null beat when no
// run fits, or up front; erase: back to idle, or an illegal beat; defragment: compaction
// pass, then tail clear
// throughput: one item at a time, the pass over the cell memory sets the rate; a result
// waits in an output register while the next item is taken; reset (rst_n low, sync):
// all cells free via per-cell valid bits, handle counter 1, mem_size 128, no clearing pass
module first_fit_block_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  // input beat
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // func [1:0], req_len [9:2], erase_handle [25:10], zero pad [31:26]
  input  logic [ffba_pkg::IN_TDATA_W-1:0]  in_tdata,
  // result beat
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // status [1:0], given_handle [16:2], zero pad [23:17]
  output logic [ffba_pkg::OUT_TDATA_W-1:0] out_tdata,
  // mem_size register write
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ffba_pkg::CFG_W-1:0]       cfg_data
);

  localparam int AW = ffba_pkg::ADDR_W;
  localparam int CW = ffba_pkg::CNT_W;
  localparam int HB = ffba_pkg::HANDLE_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN_A, S_FILL, S_SCAN_E, S_SCAN_D, S_CLEAR, S_REPLY
  } state_t;

  // cell store: one write and one registered read per cycle
  logic [HB-1:0] mem [ffba_pkg::CELLS];
  logic [HB-1:0] rd_q;

  state_t                         state_r, state_nxt;
  logic [ffba_pkg::CFG_W-1:0]     mem_size_r, mem_size_nxt;
  logic [HB-1:0]                  next_handle_r, next_handle_nxt;
  logic [ffba_pkg::LEN_W-1:0]     len_r, len_nxt;
  logic [ffba_pkg::EH_W-1:0]      eh_r, eh_nxt;
  logic [CW-1:0]                  issue_r, issue_nxt;
  logic                           pv_r, pv_nxt;
  logic [AW-1:0]                  pidx_r, pidx_nxt;
  logic [CW-1:0]                  run_r, run_nxt;
  logic                           found_r, found_nxt;
  logic [AW-1:0]                  fill_r, fill_nxt;
  logic [AW-1:0]                  end_r, end_nxt;
  logic [CW-1:0]                  w_r, w_nxt;
  logic [ffba_pkg::STATUS_W-1:0]  rs_status_r, rs_status_nxt;
  logic [ffba_pkg::GH_W-1:0]      rs_handle_r, rs_handle_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [ffba_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [ffba_pkg::GH_W-1:0]      out_handle_r, out_handle_nxt;
  logic [ffba_pkg::CELLS-1:0]     cell_vld_r, cell_vld_nxt;
  logic                           rd_vld_r, rd_vld_nxt;

  // memory port controls
  logic          we;
  logic [AW-1:0] wa;
  logic [HB-1:0] wd;
  logic [AW-1:0] rd_addr;

  logic [CW-1:0]                 n_act;
  logic [HB-1:0]                 cur_owner;
  logic                          scan_end;
  logic                          in_acc;
  logic [ffba_pkg::FUNC_W-1:0]   in_func;
  logic [ffba_pkg::LEN_W-1:0]    in_len;
  logic [ffba_pkg::EH_W-1:0]     in_eh;

  assign in_func = in_tdata[1:0];
  assign in_len  = in_tdata[9:2];
  assign in_eh   = in_tdata[25:10];

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = ffba_pkg::OUT_TDATA_W'({out_handle_r, out_status_r});

  // active cell count saturates at the built size
  always_comb begin
    if (32'(mem_size_r) > ffba_pkg::CELLS) begin
      n_act = CW'(ffba_pkg::CELLS);
    end else begin
      n_act = CW'(mem_size_r);
    end
  end

  // a cell never written reads as free
  assign cur_owner = rd_vld_r ? rd_q : '0;
  assign rd_addr   = issue_r[AW-1:0];
  assign scan_end  = (issue_r == n_act) && !pv_r;

  always_comb begin
    state_nxt       = state_r;
    mem_size_nxt    = mem_size_r;
    next_handle_nxt = next_handle_r;
    len_nxt         = len_r;
    eh_nxt          = eh_r;
    issue_nxt       = issue_r;
    pv_nxt          = 1'b0;
    pidx_nxt        = pidx_r;
    run_nxt         = run_r;
    found_nxt       = found_r;
    fill_nxt        = fill_r;
    end_nxt         = end_r;
    w_nxt           = w_r;
    rs_status_nxt   = rs_status_r;
    rs_handle_nxt   = rs_handle_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_handle_nxt  = out_handle_r;
    we              = 1'b0;
    wa              = '0;
    wd              = '0;

    if (cfg_valid && cfg_ready) begin
      mem_size_nxt = cfg_data;
    end

    // result register drains independently of the sequencer
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // read issue, shared by all scan passes
    if (state_r == S_SCAN_A || state_r == S_SCAN_E || state_r == S_SCAN_D) begin
      if (issue_r < n_act) begin
        issue_nxt = issue_r + 1'b1;
        pv_nxt    = 1'b1;
        pidx_nxt  = issue_r[AW-1:0];
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          issue_nxt     = '0;
          run_nxt       = '0;
          found_nxt     = 1'b0;
          w_nxt         = '0;
          len_nxt       = in_len;
          eh_nxt        = in_eh;
          rs_handle_nxt = '0;
          case (in_func)
            ffba_pkg::FUNC_ALLOC: begin
              if (in_len == '0 || next_handle_r >= ffba_pkg::HANDLE_MAX) begin
                rs_status_nxt = ffba_pkg::ST_NULL;
                state_nxt     = S_REPLY;
              end else begin
                state_nxt = S_SCAN_A;
              end
            end
            ffba_pkg::FUNC_ERASE: begin
              // zero or negative handle is rejected up front
              if (in_eh == '0 || in_eh[ffba_pkg::EH_W-1]) begin
                rs_status_nxt = ffba_pkg::ST_ILLEGAL;
                state_nxt     = S_REPLY;
              end else begin
                state_nxt = S_SCAN_E;
              end
            end
            ffba_pkg::FUNC_DEFRAG: begin
              state_nxt = S_SCAN_D;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN_A: begin
        if (pv_r) begin
          if (cur_owner == '0) begin
            if (32'(run_r) + 1 == 32'(len_r)) begin
              // run ends at this cell, starts run_r cells earlier
              fill_nxt  = pidx_r - AW'(run_r);
              end_nxt   = pidx_r;
              state_nxt = S_FILL;
            end else begin
              run_nxt = run_r + 1'b1;
            end
          end else begin
            run_nxt = '0;
          end
        end else if (scan_end) begin
          rs_status_nxt = ffba_pkg::ST_NULL;
          state_nxt     = S_REPLY;
        end
      end

      S_FILL: begin
        we = 1'b1;
        wa = fill_r;
        wd = next_handle_r;
        if (fill_r == end_r) begin
          next_handle_nxt = next_handle_r + 1'b1;
          rs_status_nxt   = ffba_pkg::ST_OK;
          rs_handle_nxt   = ffba_pkg::GH_W'(next_handle_r);
          state_nxt       = S_REPLY;
        end else begin
          fill_nxt = fill_r + 1'b1;
        end
      end

      S_SCAN_E: begin
        // the write goes behind the read pointer, no overlap
        if (pv_r && (32'(cur_owner) == 32'(eh_r))) begin
          we        = 1'b1;
          wa        = pidx_r;
          wd        = '0;
          found_nxt = 1'b1;
        end
        if (scan_end) begin
          if (found_r) begin
            state_nxt = S_IDLE;
          end else begin
            rs_status_nxt = ffba_pkg::ST_ILLEGAL;
            state_nxt     = S_REPLY;
          end
        end
      end

      S_SCAN_D: begin
        // compaction write pointer never passes the read pointer
        if (pv_r && cur_owner != '0) begin
          we    = 1'b1;
          wa    = w_r[AW-1:0];
          wd    = cur_owner;
          w_nxt = w_r + 1'b1;
        end
        if (scan_end) begin
          state_nxt = S_CLEAR;
        end
      end

      S_CLEAR: begin
        if (w_r < n_act) begin
          we    = 1'b1;
          wa    = w_r[AW-1:0];
          wd    = '0;
          w_nxt = w_r + 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_REPLY: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = rs_status_r;
          out_handle_nxt = rs_handle_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cell_vld_nxt = cell_vld_r;
    if (we) begin
      cell_vld_nxt[wa] = 1'b1;
    end
    rd_vld_nxt = cell_vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      mem_size_r    <= ffba_pkg::MEM_SIZE_RST;
      next_handle_r <= HB'(1);
      issue_r       <= '0;
      pv_r          <= 1'b0;
      run_r         <= '0;
      found_r       <= 1'b0;
      w_r           <= '0;
      out_valid_r   <= 1'b0;
      cell_vld_r    <= '0;
      rd_vld_r      <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      mem_size_r    <= mem_size_nxt;
      next_handle_r <= next_handle_nxt;
      issue_r       <= issue_nxt;
      pv_r          <= pv_nxt;
      run_r         <= run_nxt;
      found_r       <= found_nxt;
      w_r           <= w_nxt;
      out_valid_r   <= out_valid_nxt;
      cell_vld_r    <= cell_vld_nxt;
      rd_vld_r      <= rd_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    len_r        <= len_nxt;
    eh_r         <= eh_nxt;
    pidx_r       <= pidx_nxt;
    fill_r       <= fill_nxt;
    end_r        <= end_nxt;
    rs_status_r  <= rs_status_nxt;
    rs_handle_r  <= rs_handle_nxt;
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
  end

endmodule

// File: dv/first_fit_block_allocator_test.sv
// self-checking test of first_fit_block_allocator: directed and random alloc, erase and
// defragment beats checked against an in-bench model of the cell row and handle counter
// depends on ffba_pkg and the first_fit_block_allocator rtl
module first_fit_block_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 10;
  localparam int RESET_HOLD  = 8;
  // long enough for a defragment at full size, so this covers any silent op
  localparam int REST_CYCLES = 2 * ffba_pkg::CELLS + 40;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int QUEUE_AHEAD = 4;

  // field offsets inside the request beat
  localparam int LEN_LO = ffba_pkg::FUNC_W;
  localparam int EH_LO  = ffba_pkg::FUNC_W + ffba_pkg::LEN_W;

  // opcode the block must ignore
  localparam logic [ffba_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [ffba_pkg::STATUS_W-1:0] status;
    logic [ffba_pkg::GH_W-1:0]     handle;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  // func [1:0], req_len [9:2], erase_handle [25:10], zero pad [31:26]
  logic [ffba_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  // status [1:0], given_handle [16:2], zero pad [23:17]
  logic [ffba_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [ffba_pkg::CFG_W-1:0]       cfg_data = '0;

  // model of the allocator: cell owners, handle counter, size register
  logic [ffba_pkg::HANDLE_BITS-1:0] owner_of [ffba_pkg::CELLS];
  logic [ffba_pkg::HANDLE_BITS-1:0] handle_ctr;
  logic [ffba_pkg::CFG_W-1:0]       mem_size_q;

  logic [ffba_pkg::IN_TDATA_W-1:0] request_q [$];
  result_t                         pending_results [$];
  result_t                         oldest;

  // traffic shaping
  bit in_fire = 1'b0;
  bit idle_on = 1'b0;
  int gap_left = 0;
  int burst_left = 1;
  int stall_left = 0;

  int errors = 0;
  int cycles = 0;

  first_fit_block_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // run guard: a hang anywhere ends here
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [ffba_pkg::IN_TDATA_W-1:0] pack_beat(
      logic [ffba_pkg::FUNC_W-1:0] f,
      logic [ffba_pkg::LEN_W-1:0]  len,
      logic [ffba_pkg::EH_W-1:0]   eh);
    pack_beat = {{(ffba_pkg::IN_TDATA_W - EH_LO - ffba_pkg::EH_W){1'b0}}, eh, len, f};
  endfunction

  // model update for one accepted request beat; queues the result it causes, if any
  task automatic apply_request(input logic [ffba_pkg::IN_TDATA_W-1:0] beat);
    logic [ffba_pkg::FUNC_W-1:0] f;
    logic [ffba_pkg::LEN_W-1:0]  len;
    logic [ffba_pkg::EH_W-1:0]   eh;
    int act, run, n_len, w;
    bit hit;
    result_t r;
    f     = beat[ffba_pkg::FUNC_W-1:0];
    len   = beat[LEN_LO+ffba_pkg::LEN_W-1:LEN_LO];
    eh    = beat[EH_LO+ffba_pkg::EH_W-1:EH_LO];
    act   = (mem_size_q > ffba_pkg::CELLS) ? ffba_pkg::CELLS : int'(mem_size_q);
    n_len = int'(len);
    r.status = ffba_pkg::ST_NULL;
    r.handle = '0;
    case (f)
      ffba_pkg::FUNC_ALLOC: begin
        // first fit: lowest run of free cells, counter must not be exhausted
        if (n_len != 0 && handle_ctr < ffba_pkg::HANDLE_MAX) begin
          run = 0;
          for (int j = 0; j < act && r.status != ffba_pkg::ST_OK; j++) begin
            if (owner_of[j] == '0) begin
              run++;
              if (run == n_len) begin
                for (int k = j + 1 - n_len; k <= j; k++) owner_of[k] = handle_ctr;
                r.status = ffba_pkg::ST_OK;
                r.handle = handle_ctr;
                handle_ctr = handle_ctr + 1'b1;
              end
            end else begin
              run = 0;
            end
          end
        end
        pending_results = {pending_results, r};
      end
      ffba_pkg::FUNC_ERASE: begin
        // non-positive handles and handles owning no active cell are illegal
        hit = 1'b0;
        if (eh != '0 && !eh[ffba_pkg::EH_W-1]) begin
          for (int j = 0; j < act; j++)
            if (owner_of[j] == eh[ffba_pkg::HANDLE_BITS-1:0]) hit = 1'b1;
        end
        if (hit) begin
          for (int j = 0; j < act; j++)
            if (owner_of[j] == eh[ffba_pkg::HANDLE_BITS-1:0]) owner_of[j] = '0;
        end else begin
          r.status = ffba_pkg::ST_ILLEGAL;
          pending_results = {pending_results, r};
        end
      end
      ffba_pkg::FUNC_DEFRAG: begin
        // compaction keeps order, then the tail of the active range is freed
        w = 0;
        for (int j = 0; j < act; j++) begin
          if (owner_of[j] != '0) begin
            owner_of[w] = owner_of[j];
            w++;
          end
        end
        while (w < act) begin
          owner_of[w] = '0;
          w++;
        end
      end
      default: ;
    endcase
  endtask

  // monitor: sample on the rising edge; check results before predicting new ones
  always @(posedge clk) begin
    in_fire <= rst_n && in_tvalid && in_tready;
    if (!rst_n) begin
      for (int j = 0; j < ffba_pkg::CELLS; j++) owner_of[j] = '0;
      handle_ctr = ffba_pkg::HANDLE_BITS'(1);
      mem_size_q = ffba_pkg::MEM_SIZE_RST;
    end else begin
      if (cfg_valid && cfg_ready) mem_size_q = cfg_data;
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing pending: tdata %h", out_tdata);
          errors++;
        end else begin
          oldest = pending_results.pop_front();
          if (out_tdata[ffba_pkg::STATUS_W-1:0] != oldest.status) begin
            $error("status: expected %0d, actual %0d", oldest.status,
                   out_tdata[ffba_pkg::STATUS_W-1:0]);
            errors++;
          end
          if (out_tdata[ffba_pkg::STATUS_W+ffba_pkg::GH_W-1:ffba_pkg::STATUS_W]
              != oldest.handle) begin
            $error("given_handle: expected %0d, actual %0d", oldest.handle,
                   out_tdata[ffba_pkg::STATUS_W+ffba_pkg::GH_W-1:ffba_pkg::STATUS_W]);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) apply_request(in_tdata);
    end
  end

  // driver: beats change on the falling edge, in bursts with random gaps
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (request_q.size() > 0) begin
        in_tdata  <= request_q.pop_front();
        in_tvalid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          // with idling on, a quarter of the bursts run straight into the next one; with it off, all do
          gap_left = (idle_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 12) : 0;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stall runs of its own, none while idling is off
  always @(negedge clk) begin
    if (!idle_on || stall_left == 0) begin
      out_tready <= 1'b1;
      if (idle_on && $urandom_range(0, 99) < 20) stall_left = $urandom_range(1, 10);
    end else begin
      out_tready <= 1'b0;
      stall_left--;
    end
  end

  task automatic push_req(input logic [ffba_pkg::FUNC_W-1:0] f, input int len, input int eh);
    while (request_q.size() >= QUEUE_AHEAD) @(posedge clk);
    request_q = {request_q,
                 pack_beat(f, ffba_pkg::LEN_W'(len), ffba_pkg::EH_W'(eh))};
  endtask

  // wait until every beat is in, every result is out, and silent ops have finished
  task automatic drain_and_rest();
    do @(posedge clk);
    while (request_q.size() != 0 || in_tvalid || pending_results.size() != 0);
    repeat (REST_CYCLES) @(posedge clk);
  endtask

  task automatic write_mem_size(input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= ffba_pkg::CFG_W'(value);
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed traffic: short allocs, erases of recent handles, defragments, ignored opcodes
  task automatic random_ops(input int count);
    int done_ops, act, pick, base, len;
    done_ops = 0;
    while (done_ops < count) begin
      act = (mem_size_q > ffba_pkg::CELLS) ? ffba_pkg::CELLS : int'(mem_size_q);
      if (act == 0) act = 1;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        case ($urandom_range(0, 19))
          0:       len = $urandom_range(0, 255);
          1, 2, 3: len = $urandom_range(1, act);
          default: len = $urandom_range(1, (act / 3 > 1) ? act / 3 : 1);
        endcase
        push_req(ffba_pkg::FUNC_ALLOC, len, $urandom_range(0, 65535));
      end else if (pick < 80) begin
        base = int'(handle_ctr);
        base -= int'($urandom_range(1, 24));
        if (base < 1) base = 1;
        case ($urandom_range(0, 19))
          0:       base = 0;
          1, 2:    base = $urandom_range(0, 65535);
          default: ;
        endcase
        push_req(ffba_pkg::FUNC_ERASE, $urandom_range(0, 255), base);
      end else if (pick < 95) begin
        push_req(ffba_pkg::FUNC_DEFRAG, $urandom_range(0, 255), $urandom_range(0, 65535));
      end else begin
        // ignored opcode, not counted
        push_req(FUNC_UNUSED, $urandom_range(0, 255), $urandom_range(0, 65535));
        done_ops--;
      end
      done_ops++;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (RESET_HOLD) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: a small row so holes, full and first fit are easy to hit
    write_mem_size(8);
    push_req(ffba_pkg::FUNC_ALLOC, 0, 0);          // zero length is null
    push_req(ffba_pkg::FUNC_ALLOC, 3, 0);
    push_req(ffba_pkg::FUNC_ALLOC, 2, 0);
    push_req(ffba_pkg::FUNC_ALLOC, 4, 0);          // no room
    push_req(ffba_pkg::FUNC_ALLOC, 3, 0);          // fills the row
    push_req(ffba_pkg::FUNC_ALLOC, 1, 0);
    push_req(ffba_pkg::FUNC_ERASE, 0, 2);          // frees a hole in the middle
    push_req(ffba_pkg::FUNC_ERASE, 0, 2);          // already gone
    push_req(ffba_pkg::FUNC_ERASE, 0, 0);
    push_req(ffba_pkg::FUNC_ERASE, 0, 16'hFFFF);   // negative
    push_req(ffba_pkg::FUNC_ERASE, 0, 16'h8000);   // most negative
    push_req(ffba_pkg::FUNC_ERASE, 255, 16'h7FFF); // largest positive, never given
    push_req(FUNC_UNUSED, 255, 16'hFFFF);
    push_req(ffba_pkg::FUNC_ALLOC, 2, 0);          // first fit lands in the hole
    push_req(ffba_pkg::FUNC_ERASE, 0, 1);
    push_req(ffba_pkg::FUNC_DEFRAG, 0, 0);
    push_req(ffba_pkg::FUNC_ALLOC, 3, 0);
    push_req(ffba_pkg::FUNC_ALLOC, 255, 16'hFFFF);
    push_req(ffba_pkg::FUNC_ALLOC, 128, 0);
    push_req(ffba_pkg::FUNC_ERASE, 0, 5);
    push_req(ffba_pkg::FUNC_DEFRAG, 255, 16'hFFFF);
    drain_and_rest();

    // size above the cell count saturates
    write_mem_size(255);
    push_req(ffba_pkg::FUNC_ALLOC, 128, 0);
    push_req(ffba_pkg::FUNC_ALLOC, 100, 0);
    push_req(ffba_pkg::FUNC_DEFRAG, 0, 0);
    push_req(ffba_pkg::FUNC_ALLOC, 128, 0);
    drain_and_rest();

    // no active cells: every alloc null, every erase illegal
    write_mem_size(0);
    push_req(ffba_pkg::FUNC_ALLOC, 1, 0);
    push_req(ffba_pkg::FUNC_ERASE, 0, 3);
    push_req(ffba_pkg::FUNC_DEFRAG, 0, 0);
    push_req(ffba_pkg::FUNC_ALLOC, 0, 0);
    drain_and_rest();

    // random phases over several sizes
    idle_on = 1'b1;
    write_mem_size(128);
    random_ops(250);
    drain_and_rest();
    write_mem_size(255);
    random_ops(150);
    drain_and_rest();
    idle_on = 1'b0;
    write_mem_size(24);
    random_ops(300);
    drain_and_rest();
    idle_on = 1'b1;
    random_ops(300);
    drain_and_rest();
    write_mem_size(6);
    random_ops(450);
    drain_and_rest();
    write_mem_size(1);
    random_ops(200);
    drain_and_rest();
    write_mem_size(60);
    random_ops(300);
    drain_and_rest();

    // a last phase on a 16-cell row
    write_mem_size(16);
    random_ops(100);
    drain_and_rest();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
